[rtl/tabular_q_learning_engine_core_defines.svh]
// Assertion macros shared by the Q-learning engine RTL.
`ifndef TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TQLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TQLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tqle_pkg.sv]
// Types, codes and defaults of the Q-learning engine.
package tqle_pkg;

  localparam int DEF_MAX_STATES  = 4096;
  localparam int DEF_MAX_ACTIONS = 8;
  localparam int DEF_MAX_DIMS    = 3;

  localparam int Q_WIDTH = 16;
  localparam logic signed [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
  localparam logic signed [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

  localparam logic [1:0] MODE_CHOOSE = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_WRITE  = 2'd3;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_STATE  = 2'd1;
  localparam logic [1:0] ERR_ACTION = 2'd2;

  localparam logic [2:0] CFG_NUM_ACTIONS   = 3'd0;
  localparam logic [2:0] CFG_LEARNING_RATE = 3'd1;
  localparam logic [2:0] CFG_DISCOUNT      = 3'd2;
  localparam logic [2:0] CFG_GREEDY_THR    = 3'd3;
  localparam logic [2:0] CFG_DIM_SIZE_X    = 3'd4;
  localparam logic [2:0] CFG_DIM_SIZE_Y    = 3'd5;
  localparam logic [2:0] CFG_DIM_SIZE_Z    = 3'd6;

  localparam int CFG_DATA_W = 17;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        state_x;
    logic [11:0]        state_y;
    logic [11:0]        state_z;
    logic [11:0]        next_x;
    logic [11:0]        next_y;
    logic [11:0]        next_z;
    logic [2:0]         action_in;
    logic signed [15:0] reward_or_value;
    logic [15:0]        rand_frac;
    logic [15:0]        rand_pick;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         action_out;
    logic signed [15:0] q_value_out;
    logic               greedy_taken;
    logic [1:0]         error_code;
  } out_word_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] z;
  } coord_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [12:0] z;
  } dims_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] dim;
  } idx_ctl_t;

endpackage

[rtl/tqle_index.sv]
// Mixed-radix state index unit: one coordinate folded in per step.
module tqle_index #(
  parameter int MAX_STATES = tqle_pkg::DEF_MAX_STATES,
  parameter int SW         = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
  input  logic               clk,
  input  tqle_pkg::idx_ctl_t ctl,
  input  tqle_pkg::dims_t    dims,
  input  tqle_pkg::coord_t   coord,
  output logic [SW-1:0]      idx,
  output logic               bad
);
  import tqle_pkg::*;

  localparam int PW = SW + 14;

  logic [SW-1:0] acc_r, acc_nxt;
  logic          bad_r, bad_nxt;
  logic [11:0]   co;
  logic [12:0]   dm;
  logic [PW-1:0] prod;

  always_comb begin
    case (ctl.dim)
      2'd0: begin
        co = coord.x;
        dm = dims.x;
      end
      2'd1: begin
        co = coord.y;
        dm = dims.y;
      end
      default: begin
        co = coord.z;
        dm = dims.z;
      end
    endcase
    prod = PW'(acc_r) * PW'(dm) + PW'(co);
    acc_nxt = acc_r;
    bad_nxt = bad_r;
    if (ctl.load) begin
      acc_nxt = '0;
      bad_nxt = 1'b0;
    end else if (ctl.step) begin
      // the index only grows, so an overflow anywhere spoils the end result
      acc_nxt = prod[SW-1:0];
      bad_nxt = bad_r || ({1'b0, co} >= dm) || (prod >= PW'(MAX_STATES));
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    bad_r <= bad_nxt;
  end

  assign idx = acc_r;
  assign bad = bad_r;

endmodule

[rtl/tabular_q_learning_engine_core.sv]
// Sequence: S_INDEX folds in MAX_DIMS coordinates, then S_CHECK answers errors and writes;
// a read or random choice passes S_RDQ, a greedy choice S_SCAN, S_SCAN_END and S_FIN0,
// an update S_SCAN, S_SCAN_END, S_MUL1, S_MUL2 and S_UPD. Results cannot be stalled.
// Throughput: one word at a time, set by the one-coordinate-per-cycle index unit and
// the single read port scanning na entries. Reset: synchronous, active low; then a
// clearing pass zeroes all MAX_STATES*MAX_ACTIONS entries (32768 by default), busy high.
`include "tabular_q_learning_engine_core_defines.svh"

module tabular_q_learning_engine_core #(
  parameter int MAX_STATES  = tqle_pkg::DEF_MAX_STATES,
  parameter int MAX_ACTIONS = tqle_pkg::DEF_MAX_ACTIONS,
  parameter int MAX_DIMS    = tqle_pkg::DEF_MAX_DIMS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tqle_pkg::in_word_t                in_word,
  output logic                              out_strobe,
  output tqle_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [tqle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tqle_pkg::*;

  localparam int SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int KW    = $clog2(MAX_ACTIONS);
  localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INDEX, S_CHECK, S_SCAN, S_SCAN_END,
    S_FIN0, S_RDQ, S_MUL1, S_MUL2, S_UPD
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [3:0]  num_actions_r;
  logic [15:0] learning_rate_r, discount_r;
  logic [16:0] greedy_thr_r;
  dims_t       dims_r;

  // table
  logic signed [Q_WIDTH-1:0] mem [DEPTH];
  logic signed [Q_WIDTH-1:0] rdata_r;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic signed [Q_WIDTH-1:0] mem_wdata;

  in_word_t  in_r, in_nxt;
  out_word_t out_r, out_nxt;
  logic      out_strobe_r, out_strobe_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    dcnt_r, dcnt_nxt;
  logic [AW-1:0] scan_base_r, scan_base_nxt;
  logic [KW-1:0] k_r, k_nxt, rk_r, rk_nxt, best_r, best_nxt;
  logic          rv_r, rv_nxt;
  logic signed [Q_WIDTH-1:0] m_r, m_nxt, qc_r, qc_nxt;
  logic signed [32:0] pg_r, pg_nxt;
  logic signed [35:0] pa_r, pa_nxt;

  idx_ctl_t      idx_ctl;
  logic [SW-1:0] cur_idx, nxt_idx;
  logic          cur_bad, nxt_bad;
  coord_t        cur_coord, nxt_coord;

  logic [3:0]    na;
  logic [KW-1:0] na_m1;
  logic [19:0]   pick_prod;
  logic [KW-1:0] pick_k;
  logic [AW-1:0] cur_base, nxt_base, cell_addr;
  logic          greedy_sel;
  logic [2:0]    err_act;

  logic signed [16:0] pg_hi;
  logic signed [17:0] tgt;
  logic signed [18:0] diff;
  logic signed [19:0] pa_hi;
  logic signed [20:0] sum;
  logic signed [Q_WIDTH-1:0] q_new;

  assign cur_coord = '{x: in_r.state_x, y: in_r.state_y, z: in_r.state_z};
  assign nxt_coord = '{x: in_r.next_x, y: in_r.next_y, z: in_r.next_z};

  tqle_index #(.MAX_STATES(MAX_STATES), .SW(SW)) u_cur_idx (
    .clk(clk), .ctl(idx_ctl), .dims(dims_r), .coord(cur_coord),
    .idx(cur_idx), .bad(cur_bad)
  );

  tqle_index #(.MAX_STATES(MAX_STATES), .SW(SW)) u_nxt_idx (
    .clk(clk), .ctl(idx_ctl), .dims(dims_r), .coord(nxt_coord),
    .idx(nxt_idx), .bad(nxt_bad)
  );

  always_comb begin
    if (num_actions_r == 4'd0) begin
      na = 4'd1;
    end else if (32'(num_actions_r) > MAX_ACTIONS) begin
      na = 4'(MAX_ACTIONS);
    end else begin
      na = num_actions_r;
    end
    na_m1      = KW'(na - 4'd1);
    pick_prod  = 20'(in_r.rand_pick) * 20'(na);
    pick_k     = KW'(pick_prod[19:16]);
    cur_base   = AW'(32'(cur_idx) * MAX_ACTIONS);
    nxt_base   = AW'(32'(nxt_idx) * MAX_ACTIONS);
    cell_addr  = cur_base + AW'(in_r.action_in);
    greedy_sel = {1'b0, in_r.rand_frac} < greedy_thr_r;
    err_act    = (in_r.mode == MODE_CHOOSE) ? 3'd0 : in_r.action_in;

    // update arithmetic, floor shifts by taking the upper bits
    pg_hi = $signed(pg_r[32:16]);
    tgt   = 18'(in_r.reward_or_value) + 18'(pg_hi);
    diff  = 19'(tgt) - 19'(qc_r);
    pa_hi = $signed(pa_r[35:16]);
    sum   = 21'(qc_r) + 21'(pa_hi);
    if (sum > 21'(Q_MAX)) begin
      q_new = Q_MAX;
    end else if (sum < 21'(Q_MIN)) begin
      q_new = Q_MIN;
    end else begin
      q_new = sum[Q_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    clr_nxt        = clr_r;
    dcnt_nxt       = dcnt_r;
    scan_base_nxt  = scan_base_r;
    k_nxt          = k_r;
    rk_nxt         = rk_r;
    rv_nxt         = 1'b0;
    best_nxt       = best_r;
    m_nxt          = m_r;
    qc_nxt         = qc_r;
    pg_nxt         = pg_r;
    pa_nxt         = pa_r;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr;
    mem_wdata      = in_r.reward_or_value;
    mem_raddr      = cell_addr;
    idx_ctl        = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt       = in_word;
          idx_ctl.load = 1'b1;
          dcnt_nxt     = 2'd0;
          state_nxt    = S_INDEX;
        end
      end
      S_INDEX: begin
        idx_ctl.step = 1'b1;
        idx_ctl.dim  = dcnt_r;
        dcnt_nxt     = dcnt_r + 2'd1;
        if (dcnt_r == 2'(MAX_DIMS - 1)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        k_nxt = '0;
        if (cur_bad || (in_r.mode == MODE_UPDATE && nxt_bad)) begin
          out_nxt        = '{action_out: err_act, q_value_out: '0,
                             greedy_taken: 1'b0, error_code: ERR_STATE};
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (in_r.mode != MODE_CHOOSE && {1'b0, in_r.action_in} >= na) begin
          out_nxt        = '{action_out: err_act, q_value_out: '0,
                             greedy_taken: 1'b0, error_code: ERR_ACTION};
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          case (in_r.mode)
            MODE_CHOOSE: begin
              if (greedy_sel) begin
                scan_base_nxt = cur_base;
                state_nxt     = S_SCAN;
              end else begin
                mem_raddr = cur_base + AW'(pick_k);
                best_nxt  = pick_k;
                state_nxt = S_RDQ;
              end
            end
            MODE_UPDATE: begin
              scan_base_nxt = nxt_base;
              state_nxt     = S_SCAN;
            end
            MODE_READ: begin
              best_nxt  = KW'(in_r.action_in);
              state_nxt = S_RDQ;
            end
            default: begin
              mem_we         = 1'b1;
              out_nxt        = '{action_out: in_r.action_in,
                                 q_value_out: in_r.reward_or_value,
                                 greedy_taken: 1'b0, error_code: ERR_OK};
              out_strobe_nxt = 1'b1;
              state_nxt      = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = scan_base_r + AW'(k_r);
        rv_nxt    = 1'b1;
        rk_nxt    = k_r;
        k_nxt     = k_r + KW'(1);
        if (k_r == na_m1) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last entry compares this cycle; the cell read goes out meanwhile
        state_nxt = (in_r.mode == MODE_CHOOSE) ? S_FIN0 : S_MUL1;
      end
      S_FIN0: begin
        out_nxt        = '{action_out: 3'(best_r), q_value_out: m_r,
                           greedy_taken: 1'b1, error_code: ERR_OK};
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_RDQ: begin
        out_nxt        = '{action_out: 3'(best_r), q_value_out: rdata_r,
                           greedy_taken: 1'b0, error_code: ERR_OK};
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_MUL1: begin
        qc_nxt    = rdata_r;
        pg_nxt    = $signed({1'b0, discount_r}) * m_r;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        pa_nxt    = $signed({1'b0, learning_rate_r}) * diff;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        mem_we         = 1'b1;
        mem_wdata      = q_new;
        out_nxt        = '{action_out: in_r.action_in, q_value_out: q_new,
                           greedy_taken: 1'b0, error_code: ERR_OK};
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // running maximum, first one wins on a tie
    if (rv_r && (rk_r == '0 || rdata_r > m_r)) begin
      m_nxt    = rdata_r;
      best_nxt = rk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      out_strobe_r    <= 1'b0;
      rv_r            <= 1'b0;
      dcnt_r          <= '0;
      num_actions_r   <= 4'd8;
      learning_rate_r <= 16'd6554;
      discount_r      <= 16'd58982;
      greedy_thr_r    <= 17'd58982;
      dims_r          <= '{x: 13'd16, y: 13'd16, z: 13'd16};
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
      rv_r         <= rv_nxt;
      dcnt_r       <= dcnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_ACTIONS:   num_actions_r   <= cfg_wdata[3:0];
          CFG_LEARNING_RATE: learning_rate_r <= cfg_wdata[15:0];
          CFG_DISCOUNT:      discount_r      <= cfg_wdata[15:0];
          CFG_GREEDY_THR:    greedy_thr_r    <= cfg_wdata[16:0];
          CFG_DIM_SIZE_X:    dims_r.x        <= cfg_wdata[12:0];
          CFG_DIM_SIZE_Y:    dims_r.y        <= cfg_wdata[12:0];
          CFG_DIM_SIZE_Z:    dims_r.z        <= cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    out_r       <= out_nxt;
    scan_base_r <= scan_base_nxt;
    k_r         <= k_nxt;
    rk_r        <= rk_nxt;
    best_r      <= best_nxt;
    m_r         <= m_nxt;
    qc_r        <= qc_nxt;
    pg_r        <= pg_nxt;
    pa_r        <= pa_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  `TQLE_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe lasted two cycles")
  `TQLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `TQLE_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result shown while still busy")
  `TQLE_ASSERT_NOW(a_greedy_ok, out_strobe && out_word.greedy_taken,
                   out_word.error_code == ERR_OK, "greedy flag set on an error result")

endmodule
